>>> src/aep_pkg.sv
`timescale 1ns / 1ps
package aep_pkg;

  localparam int POOL_SIZE = 64;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int LINK_W    = 7;
  localparam logic [LINK_W-1:0] NIL = 7'd127;
  localparam int STAMP_W   = 31;
  localparam int LIFE_W    = 20;
  localparam int DATA_W    = 1 + 32 + STAMP_W;  // {mode, rgba, stamp}

  localparam logic [LIFE_W-1:0] LIFE_RST = 20'd10000;
  localparam logic [LIFE_W-1:0] FADE_RST = 20'd1000;
  localparam logic [7:0]        FULL_ALPHA = 8'd255;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_SWEEP = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_ALLOC = 2'd0,
    K_DRAW  = 2'd1,
    K_NONE  = 2'd2,
    K_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_LIFE   = 2'd1,
    REG_FADE   = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EV_RD, ST_EV_CMP, ST_REL0, ST_REL1,
    ST_AL_RD, ST_AL_WR, ST_AL_LINK, ST_SW_RD, ST_SW_CHK,
    ST_DV_MUL, ST_DV_STEP, ST_SW_PUSH, ST_SW_END, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [STAMP_W-1:0] now_time;
    logic               fade_alpha_only;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } item_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] slot;
    logic [6:0] evicted;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       last;
  } result_word_t;

  typedef struct packed {
    logic [1:0]        index;
    logic [LIFE_W-1:0] value;
  } cfg_word_t;

  function automatic logic link_ok(input logic [LINK_W-1:0] l);
    return l < LINK_W'(POOL_SIZE);
  endfunction

endpackage

>>> src/aep_item_if.sv
`timescale 1ns / 1ps
interface aep_item_if;
  import aep_pkg::*;
  logic       valid;
  logic       ready;
  item_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/aep_result_if.sv
`timescale 1ns / 1ps
interface aep_result_if;
  import aep_pkg::*;
  logic         valid;
  logic         ready;
  result_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/aep_cfg_if.sv
`timescale 1ns / 1ps
interface aep_cfg_if;
  import aep_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/aep_ram.sv
`timescale 1ns / 1ps
module aep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/aging_entry_pool_with_fade.sv
`timescale 1ns / 1ps
// Channel   Dir  Word           Accepted when
// cfg       in   cfg_word_t     cfg.valid & cfg.ready (ready is always high)
// item      in   item_word_t    item.valid & item.ready
// result    out  result_word_t  result.valid & result.ready
//
// Steps: allocate evicts the oldest group of equal stamps entry by entry when the pool
// is full, then takes a free slot; a sweep visits the entries, drawing or freeing each,
// and scales each faded channel with one 8x20 multiply, then 8 restoring divide steps;
// clear rewrites the link memories entry by entry.
// Reset runs a pass rebuilding the link memories; item.ready is low.
// One item at a time: item.ready is high only when the sequencer is idle.
// A stalled result register holds the sequencer at its next emit point.
module aging_entry_pool_with_fade
  import aep_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  aep_cfg_if.sink      cfg,
  aep_item_if.sink     item,
  aep_result_if.source result
);

  // configuration
  logic              enable;
  logic [LIFE_W-1:0] total_life;
  logic [LIFE_W-1:0] fade_span;

  state_t state, state_next;

  // list heads
  logic [LINK_W-1:0] free_head, newest, oldest;

  // latched item
  logic [STAMP_W-1:0] now_r;
  logic               mode_in;
  logic [3:0][7:0]    col_in;

  // sequencer working registers
  logic [LINK_W-1:0]  clr_cnt;
  logic               clr_emit;
  logic [6:0]         ev;
  logic [STAMP_W-1:0] ts;
  logic [LINK_W-1:0]  rel_s, rel_p, rel_n;
  logic               rel_sweep;
  logic [LINK_W-1:0]  slot_r, cur, nx;
  logic [6:0]         steps;
  logic [LIFE_W-1:0]  t_r;
  logic [3:0][7:0]    col;
  logic               mode_w;
  logic [1:0]         ch;
  logic [27:0]        num;
  logic [7:0]         q;
  logic [2:0]         bit_i;
  result_word_t       pend, res, ow;
  logic               pend_v, ov;

  // memories
  logic              dt_we, nx_we, pv_we;
  logic [IDX_W-1:0]  dt_wa, nx_wa, pv_wa, rd_a;
  logic [DATA_W-1:0] dt_wd, dt_q;
  logic [LINK_W-1:0] nx_wd, pv_wd, next_q, prev_q;

  aep_ram #(.WIDTH(DATA_W), .DEPTH(POOL_SIZE)) u_data (
    .clk, .we(dt_we), .waddr(dt_wa), .wdata(dt_wd), .raddr(rd_a), .rdata(dt_q));
  aep_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SIZE)) u_next (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(rd_a), .rdata(next_q));
  aep_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SIZE)) u_prev (
    .clk, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(rd_a), .rdata(prev_q));

  // read data fields
  logic [STAMP_W-1:0] rd_stamp;
  logic [31:0]        end_t, t_diff;
  logic               expired, fades;
  logic               out_free;
  logic [27:0]        dv_cmp;
  logic               dv_hit;
  logic [7:0]         mul_c;
  logic               dv_done;

  assign rd_stamp = dt_q[STAMP_W-1:0];
  assign end_t    = {1'b0, rd_stamp} + 32'(total_life);
  assign expired  = {1'b0, now_r} > end_t;
  assign t_diff   = end_t - {1'b0, now_r};
  assign fades    = t_diff < 32'(fade_span);
  assign out_free = !ov || result.ready;
  assign dv_cmp   = 28'(fade_span) << bit_i;
  assign dv_hit   = num >= dv_cmp;
  assign mul_c    = (ch == 2'd3) ? FULL_ALPHA : col[ch];
  assign dv_done  = mode_w || (ch == 2'd2);

  assign item.ready   = (state == ST_IDLE);
  assign cfg.ready    = 1'b1;
  assign result.valid = ov;
  assign result.data  = ow;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == LINK_W'(POOL_SIZE - 1)) begin
          state_next = clr_emit ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item.valid) begin
          case (op_t'(item.data.op))
            OP_ALLOC: state_next = (!link_ok(free_head) && link_ok(oldest)) ? ST_EV_RD
                                                                            : ST_AL_RD;
            OP_SWEEP: state_next = enable ? ST_SW_RD : ST_SW_END;
            OP_CLEAR: state_next = ST_CLEAR;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_EV_RD:  state_next = ST_EV_CMP;
      ST_EV_CMP: begin
        state_next = (ev == 7'd0 || rd_stamp == ts) ? ST_REL0 : ST_AL_RD;
      end
      ST_REL0:   state_next = ST_REL1;
      ST_REL1: begin
        if (rel_sweep) begin
          state_next = ST_SW_RD;
        end else begin
          state_next = (link_ok(oldest) && (ev + 7'd1) < 7'(POOL_SIZE)) ? ST_EV_RD
                                                                        : ST_AL_RD;
        end
      end
      ST_AL_RD:   state_next = link_ok(free_head) ? ST_AL_WR : ST_EMIT;
      ST_AL_WR:   state_next = ST_AL_LINK;
      ST_AL_LINK: state_next = ST_EMIT;
      ST_SW_RD: begin
        state_next = (!link_ok(cur) || steps == 7'(POOL_SIZE)) ? ST_SW_END : ST_SW_CHK;
      end
      ST_SW_CHK: begin
        if (expired) begin
          state_next = ST_REL0;
        end else begin
          state_next = fades ? ST_DV_MUL : ST_SW_PUSH;
        end
      end
      ST_DV_MUL:  state_next = ST_DV_STEP;
      ST_DV_STEP: begin
        if (bit_i == 3'd0) begin
          state_next = dv_done ? ST_SW_PUSH : ST_DV_MUL;
        end
      end
      ST_SW_PUSH: begin
        if (!pend_v || out_free) begin
          state_next = ST_SW_RD;
        end
      end
      ST_SW_END:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    dt_we = 1'b0;
    nx_we = 1'b0;
    pv_we = 1'b0;
    dt_wa = slot_r[IDX_W-1:0];
    nx_wa = '0;
    pv_wa = '0;
    dt_wd = {mode_in, col_in, now_r};
    nx_wd = NIL;
    pv_wd = NIL;
    rd_a  = cur[IDX_W-1:0];
    case (state)
      ST_CLEAR: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        nx_wa = clr_cnt[IDX_W-1:0];
        pv_wa = clr_cnt[IDX_W-1:0];
        nx_wd = (clr_cnt < LINK_W'(POOL_SIZE - 1)) ? clr_cnt + 7'd1 : NIL;
      end
      ST_EV_RD: rd_a = oldest[IDX_W-1:0];
      ST_REL0: begin
        nx_we = link_ok(rel_p);
        nx_wa = rel_p[IDX_W-1:0];
        nx_wd = rel_n;
        pv_we = link_ok(rel_n);
        pv_wa = rel_n[IDX_W-1:0];
        pv_wd = rel_p;
      end
      ST_REL1: begin
        nx_we = 1'b1;
        nx_wa = rel_s[IDX_W-1:0];
        nx_wd = free_head;
        pv_we = 1'b1;
        pv_wa = rel_s[IDX_W-1:0];
      end
      ST_AL_RD: rd_a = free_head[IDX_W-1:0];
      ST_AL_WR: begin
        dt_we = 1'b1;
        nx_we = 1'b1;
        nx_wa = slot_r[IDX_W-1:0];
        nx_wd = newest;
        pv_we = 1'b1;
        pv_wa = slot_r[IDX_W-1:0];
      end
      ST_AL_LINK: begin
        pv_we = link_ok(newest);
        pv_wa = newest[IDX_W-1:0];
        pv_wd = slot_r;
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b1;
      total_life <= LIFE_RST;
      fade_span  <= FADE_RST;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.data.index))
        REG_ENABLE: enable     <= cfg.data.value[0];
        REG_LIFE:   total_life <= cfg.data.value;
        REG_FADE:   fade_span  <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      clr_emit <= 1'b0;
      ov       <= 1'b0;
      pend_v   <= 1'b0;
    end else begin
      state <= state_next;
      if (result.ready) begin
        ov <= 1'b0;
      end
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 7'd1;
        ST_IDLE: begin
          clr_cnt  <= '0;
          clr_emit <= 1'b1;
          pend_v   <= 1'b0;
        end
        ST_SW_PUSH: begin
          if (!pend_v) begin
            pend_v <= 1'b1;
          end else if (out_free) begin
            ov <= 1'b1;
          end
        end
        ST_SW_END: pend_v <= 1'b0;
        ST_EMIT: begin
          if (out_free) begin
            ov <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // list heads: reset value comes in on the last cycle of the clearing pass
  always_ff @(posedge clk) begin
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == LINK_W'(POOL_SIZE - 1)) begin
          free_head <= '0;
          newest    <= NIL;
          oldest    <= NIL;
        end
      end
      ST_REL0: begin
        if (!link_ok(rel_p)) newest <= rel_n;
        if (!link_ok(rel_n)) oldest <= rel_p;
      end
      ST_REL1:  free_head <= rel_s;
      ST_AL_WR: free_head <= next_q;
      ST_AL_LINK: begin
        if (!link_ok(newest)) oldest <= slot_r;
        newest <= slot_r;
      end
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_CLEAR: res <= '{kind: K_CLEAR, last: 1'b1, default: '0};
      ST_IDLE: begin
        now_r   <= item.data.now_time;
        mode_in <= item.data.fade_alpha_only;
        col_in  <= {item.data.alpha, item.data.blue, item.data.green, item.data.red};
        ev      <= '0;
        steps   <= '0;
        cur     <= newest;
      end
      ST_EV_CMP: begin
        if (ev == 7'd0) ts <= rd_stamp;
        rel_s     <= oldest;
        rel_p     <= prev_q;
        rel_n     <= next_q;
        rel_sweep <= 1'b0;
      end
      ST_REL1: begin
        if (rel_sweep) cur <= nx;
        else           ev  <= ev + 7'd1;
      end
      ST_AL_RD: begin
        slot_r <= free_head;
        res    <= '{kind: K_ALLOC, evicted: ev, last: 1'b1, default: '0};
      end
      ST_AL_LINK: begin
        res <= '{kind: K_ALLOC, slot: 6'(slot_r), evicted: ev, last: 1'b1, default: '0};
      end
      ST_SW_CHK: begin
        steps     <= steps + 7'd1;
        nx        <= next_q;
        rel_s     <= cur;
        rel_p     <= prev_q;
        rel_n     <= next_q;
        rel_sweep <= 1'b1;
        col       <= dt_q[STAMP_W +: 32];
        mode_w    <= dt_q[DATA_W-1];
        t_r       <= t_diff[LIFE_W-1:0];
        ch        <= dt_q[DATA_W-1] ? 2'd3 : 2'd0;
      end
      ST_DV_MUL: begin
        num   <= 28'(mul_c) * 28'(t_r);
        q     <= '0;
        bit_i <= 3'd7;
      end
      ST_DV_STEP: begin
        // restoring divide, one quotient bit per cycle, msb first
        if (dv_hit) begin
          num      <= num - dv_cmp;
          q[bit_i] <= 1'b1;
        end
        bit_i <= bit_i - 3'd1;
        if (bit_i == 3'd0) begin
          col[ch] <= {q[7:1], dv_hit};
          ch      <= ch + 2'd1;
        end
      end
      ST_SW_PUSH: begin
        if (!pend_v || out_free) begin
          pend <= '{kind: K_DRAW, slot: 6'(cur), evicted: '0, out_red: col[0],
                    out_green: col[1], out_blue: col[2], out_alpha: col[3], last: 1'b0};
          cur  <= nx;
        end
        if (pend_v && out_free) begin
          ow <= pend;
        end
      end
      ST_SW_END: begin
        if (pend_v) begin
          // last draw of the sweep closes the burst
          res <= {pend[$bits(result_word_t)-1:1], 1'b1};
        end else begin
          res <= '{kind: K_NONE, last: 1'b1, default: '0};
        end
      end
      ST_EMIT: begin
        if (out_free) ow <= res;
      end
      default: ;
    endcase
  end

  // checks
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    ov && (ow.kind == K_NONE || ow.kind == K_CLEAR || ow.kind == K_ALLOC) |-> ow.last)
    else $error("non-draw word without last");

  a_ev_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_REL1 |-> ev < 7'(POOL_SIZE))
    else $error("eviction count out of range");

  a_pend_draw: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> pend.kind == K_DRAW && !pend.last)
    else $error("pending word is not a draw");

  a_clear_start: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.data.op == OP_CLEAR |=> state == ST_CLEAR)
    else $error("clear did not start");

endmodule

>>> tb/aging_entry_pool_with_fade_tb.sv
`timescale 1ns / 1ps
module aging_entry_pool_with_fade_tb;
  import aep_pkg::*;

  logic clk;
  logic rst;

  aep_cfg_if    cfg_ch();
  aep_item_if   item_ch();
  aep_result_if res_ch();

  aging_entry_pool_with_fade DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  // ---------------------------------------------------------------
  // Shadow pool: mirrors the block's lists and stores.
  // ---------------------------------------------------------------
  logic [STAMP_W-1:0] sh_stamp [POOL_SIZE];
  logic               sh_mode  [POOL_SIZE];
  logic [31:0]        sh_color [POOL_SIZE];  // {a, b, g, r}
  logic [LINK_W-1:0]  sh_next  [POOL_SIZE];
  logic [LINK_W-1:0]  sh_prev  [POOL_SIZE];
  logic [LINK_W-1:0]  sh_free, sh_newest, sh_oldest;
  logic               sh_enable;
  logic [LIFE_W-1:0]  sh_life, sh_fade;

  item_word_t   pend_q [$];   // words waiting for the driver
  result_word_t want_q [$];   // predicted result words, oldest first

  int errors;
  int n_items, n_results, n_evict_max, n_faded, n_freed;
  bit quiet;                  // no idling on either side

  function automatic bit is_slot(logic [LINK_W-1:0] l);
    return l < LINK_W'(POOL_SIZE);
  endfunction

  // link value to pool index
  function automatic logic [IDX_W-1:0] ix(logic [LINK_W-1:0] l);
    return l[IDX_W-1:0];
  endfunction

  function automatic void shadow_init();
    for (int i = 0; i < POOL_SIZE; i++) begin
      sh_next[i] = (i + 1 < POOL_SIZE) ? LINK_W'(i + 1) : NIL;
      sh_prev[i] = NIL;
    end
    sh_free   = '0;
    sh_newest = NIL;
    sh_oldest = NIL;
  endfunction

  // unlink from the active list, push onto the free list
  function automatic void shadow_unlink(logic [LINK_W-1:0] s);
    logic [LINK_W-1:0] p, n;
    p = sh_prev[ix(s)];
    n = sh_next[ix(s)];
    if (is_slot(p)) sh_next[ix(p)] = n; else sh_newest = n;
    if (is_slot(n)) sh_prev[ix(n)] = p; else sh_oldest = p;
    sh_next[ix(s)] = sh_free;
    sh_prev[ix(s)] = NIL;
    sh_free = s;
  endfunction

  function automatic void push_want(kind_t k, logic [5:0] s, logic [6:0] ev,
                                    logic [31:0] rgba);
    result_word_t r;
    r.kind      = k;
    r.slot      = s;
    r.evicted   = ev;
    r.out_red   = rgba[7:0];
    r.out_green = rgba[15:8];
    r.out_blue  = rgba[23:16];
    r.out_alpha = rgba[31:24];
    r.last      = 1'b0;
    want_q.push_back(r);
  endfunction

  // Work out every result word that one accepted item causes.
  function automatic void predict_pool(item_word_t w);
    int                first, ev, steps;
    logic [LINK_W-1:0] s, cur, nx;
    logic [STAMP_W-1:0] ts;
    longint            life_end, t;
    logic [31:0]       c;
    longint            r, g, b, a;
    first = want_q.size();
    case (op_t'(w.op))
      OP_ALLOC: begin
        ev = 0;
        if (!is_slot(sh_free) && is_slot(sh_oldest)) begin
          // full pool: drop the whole oldest group of equal stamps
          ts = sh_stamp[ix(sh_oldest)];
          while (is_slot(sh_oldest) && sh_stamp[ix(sh_oldest)] == ts && ev < POOL_SIZE) begin
            shadow_unlink(sh_oldest);
            ev++;
          end
          if (ev > n_evict_max) n_evict_max = ev;
        end
        s = sh_free;
        if (is_slot(s)) begin
          sh_free = sh_next[ix(s)];
          sh_stamp[ix(s)] = w.now_time;
          sh_mode[ix(s)]  = w.fade_alpha_only;
          sh_color[ix(s)] = {w.alpha, w.blue, w.green, w.red};
          sh_next[ix(s)]  = sh_newest;
          sh_prev[ix(s)]  = NIL;
          if (is_slot(sh_newest)) sh_prev[ix(sh_newest)] = s; else sh_oldest = s;
          sh_newest = s;
        end else begin
          s = '0;
        end
        push_want(K_ALLOC, s[5:0], 7'(ev), '0);
      end
      OP_SWEEP: begin
        if (sh_enable) begin
          cur = sh_newest;
          steps = 0;
          while (is_slot(cur) && steps < POOL_SIZE) begin
            nx = sh_next[ix(cur)];
            life_end = longint'(sh_stamp[ix(cur)]) + longint'(sh_life);
            steps++;
            if (longint'(w.now_time) > life_end) begin
              shadow_unlink(cur);
              n_freed++;
            end else begin
              t = life_end - longint'(w.now_time);
              c = sh_color[ix(cur)];
              r = c[7:0]; g = c[15:8]; b = c[23:16]; a = c[31:24];
              if (t < longint'(sh_fade)) begin
                n_faded++;
                if (sh_mode[ix(cur)]) begin
                  a = 255 * t / longint'(sh_fade);
                end else begin
                  r = r * t / longint'(sh_fade);
                  g = g * t / longint'(sh_fade);
                  b = b * t / longint'(sh_fade);
                end
              end
              push_want(K_DRAW, cur[5:0], '0, {a[7:0], b[7:0], g[7:0], r[7:0]});
            end
            cur = nx;
          end
        end
        if (want_q.size() == first) push_want(K_NONE, '0, '0, '0);
      end
      OP_CLEAR: begin
        shadow_init();
        push_want(K_CLEAR, '0, '0, '0);
      end
      default: ;  // unknown op: no result
    endcase
    if (want_q.size() > first) want_q[want_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------
  // Clock, reset
  // ---------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // ---------------------------------------------------------------
  // Driver: item words from pend_q, random gaps between words
  // ---------------------------------------------------------------
  bit item_took;
  int send_gap;

  initial begin
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    res_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
  end

  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (item_ch.valid && !item_took) begin
      // word still pending, hold it
    end else if (send_gap > 0) begin
      item_ch.valid <= 1'b0;
      send_gap--;
    end else if (pend_q.size() > 0) begin
      item_ch.data  <= pend_q.pop_front();
      item_ch.valid <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 4);
    end else begin
      item_ch.valid <= 1'b0;
    end
  end

  // result backpressure in bursts
  int stall_left;
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      res_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 4);
    end
  end

  // ---------------------------------------------------------------
  // Monitor: config and item acceptance feed the predictor,
  // result words are checked against the oldest prediction.
  // ---------------------------------------------------------------
  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_word_t e, a;
    item_took <= !rst && item_ch.valid && item_ch.ready;
    if (rst) begin
      shadow_init();
      sh_enable = 1'b1;
      sh_life   = LIFE_RST;
      sh_fade   = FADE_RST;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (reg_idx_t'(cfg_ch.data.index))
          REG_ENABLE: sh_enable = cfg_ch.data.value[0];
          REG_LIFE:   sh_life   = cfg_ch.data.value;
          REG_FADE:   sh_fade   = cfg_ch.data.value;
          default: ;
        endcase
      end
      if (item_ch.valid && item_ch.ready) begin
        n_items++;
        predict_pool(item_ch.data);
      end
      if (res_ch.valid && res_ch.ready) begin
        a = res_ch.data;
        n_results++;
        if (want_q.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none, got %h", $time, a);
          errors++;
        end else begin
          e = want_q.pop_front();
          check_field("kind",      e.kind,      a.kind);
          check_field("slot",      e.slot,      a.slot);
          check_field("evicted",   e.evicted,   a.evicted);
          check_field("out_red",   e.out_red,   a.out_red);
          check_field("out_green", e.out_green, a.out_green);
          check_field("out_blue",  e.out_blue,  a.out_blue);
          check_field("out_alpha", e.out_alpha, a.out_alpha);
          check_field("last",      e.last,      a.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  logic [STAMP_W-1:0] clock_now;  // running time base for random words

  function automatic item_word_t mk(op_t op, logic [STAMP_W-1:0] t, logic m,
                                    logic [31:0] rgba);
    item_word_t w;
    w.op = op;
    w.now_time = t;
    w.fade_alpha_only = m;
    {w.alpha, w.blue, w.green, w.red} = rgba;
    return w;
  endfunction

  // Drain everything, then give a dropped op time to finish.
  task automatic wait_drained();
    wait (pend_q.size() == 0 && !item_ch.valid && want_q.size() == 0);
    repeat (20) @(posedge clk);
    wait (item_ch.ready);
    wait (want_q.size() == 0);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [LIFE_W-1:0] val);
    @(negedge clk);
    cfg_ch.data.index = idx;
    cfg_ch.data.value = val;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_regs(logic en, logic [LIFE_W-1:0] life, logic [LIFE_W-1:0] fade);
    wait_drained();
    write_reg(REG_ENABLE, {19'd0, en});
    write_reg(REG_LIFE, life);
    write_reg(REG_FADE, fade);
  endtask

  // Mostly allocates and sweeps on an advancing time base, so entries
  // age through the fade window and expire; some noise on top.
  task automatic random_words(int count, int life);
    int pick, step;
    logic [STAMP_W-1:0] t;
    logic m;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      step = $urandom_range(0, (life / 3) + 2);
      m = 1'($urandom_range(0, 1));
      clock_now = clock_now + STAMP_W'(step);
      t = clock_now;
      if ($urandom_range(0, 19) == 0) t = STAMP_W'($urandom());        // wild time
      else if ($urandom_range(0, 19) == 0) t = clock_now - STAMP_W'(step * 3);
      if (pick < 55)
        pend_q.push_back(mk(OP_ALLOC, t, m, $urandom()));
      else if (pick < 93)
        pend_q.push_back(mk(OP_SWEEP, t, m, $urandom()));
      else if (pick < 96)
        pend_q.push_back(mk(OP_CLEAR, t, m, $urandom()));
      else
        pend_q.push_back(mk(OP_NOP, t, m, $urandom()));
    end
  endtask

  initial begin
    errors = 0;
    n_items = 0; n_results = 0; n_evict_max = 0; n_faded = 0; n_freed = 0;
    quiet = 1'b0;
    clock_now = '0;
    @(negedge rst);

    // Directed: extremes of colors and time, every op, reset registers.
    pend_q.push_back(mk(OP_SWEEP, '0, 1'b0, '0));                    // empty sweep
    pend_q.push_back(mk(OP_ALLOC, '0, 1'b0, 32'hFFFF_FFFF));
    pend_q.push_back(mk(OP_ALLOC, 31'd200, 1'b1, 32'h0000_0000));
    pend_q.push_back(mk(OP_ALLOC, 31'd9500, 1'b1, 32'h80FF_00FF));
    pend_q.push_back(mk(OP_ALLOC, 31'd9500, 1'b0, 32'h7F00_FF00));
    pend_q.push_back(mk(OP_SWEEP, 31'd9400, 1'b0, '0));              // fading
    pend_q.push_back(mk(OP_SWEEP, 31'd10000, 1'b0, '0));             // stamp 0 at end
    pend_q.push_back(mk(OP_SWEEP, 31'd10001, 1'b0, '0));             // stamp 0 expires
    pend_q.push_back(mk(OP_SWEEP, 31'd5, 1'b0, '0));                 // time backward
    pend_q.push_back(mk(OP_NOP, 31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    pend_q.push_back(mk(OP_ALLOC, 31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    pend_q.push_back(mk(OP_SWEEP, 31'h7FFF_FFFF, 1'b1, '0));         // all but newest go
    pend_q.push_back(mk(OP_CLEAR, '0, 1'b0, '0));
    pend_q.push_back(mk(OP_SWEEP, 31'h7FFF_FFFF, 1'b0, '0));

    // Full pool: one stamp group of 64, then a second group.
    for (int i = 0; i < POOL_SIZE; i++)
      pend_q.push_back(mk(OP_ALLOC, 31'd50, i[0], $urandom()));
    pend_q.push_back(mk(OP_ALLOC, 31'd60, 1'b0, $urandom()));         // evicts all 64
    for (int i = 0; i < POOL_SIZE - 4; i++)
      pend_q.push_back(mk(OP_ALLOC, 31'd70 + 31'(i / 20), i[1], $urandom()));
    for (int i = 0; i < 6; i++)
      pend_q.push_back(mk(OP_ALLOC, 31'd90, 1'b1, $urandom()));      // small-group evictions
    pend_q.push_back(mk(OP_SWEEP, 31'd9200, 1'b0, '0));

    // Disabled sweep leaves state untouched.
    set_regs(1'b0, 20'd1, 20'd1);
    pend_q.push_back(mk(OP_SWEEP, 31'h7FFF_FFFF, 1'b0, '0));
    pend_q.push_back(mk(OP_ALLOC, 31'd100, 1'b0, $urandom()));

    // Zero fade span: never fades.
    set_regs(1'b1, 20'd500, 20'd0);
    pend_q.push_back(mk(OP_SWEEP, 31'd9300, 1'b0, '0));
    pend_q.push_back(mk(OP_CLEAR, '0, 1'b0, '0));
    clock_now = 31'd1000;
    random_words(40, 500);

    // Shortest life and span.
    set_regs(1'b1, 20'd1, 20'd1);
    random_words(40, 2);

    // Large life and span (1000000); time near the top of its range.
    set_regs(1'b1, 20'd1000000, 20'd1000000);
    clock_now = 31'h7FF0_0000;
    random_words(40, 1000000);

    // Span longer than life: entries fade from birth.
    set_regs(1'b1, 20'd300, 20'd700);
    clock_now = 31'd5000;
    random_words(45, 300);

    // Disabled for a while.
    set_regs(1'b0, 20'hFFFFF, 20'hFFFFF);
    random_words(20, 1000);

    // Typical settings, then a final stretch with no idling.
    set_regs(1'b1, 20'd2000, 20'd400);
    random_words(45, 2000);
    wait_drained();
    quiet = 1'b1;
    random_words(40, 2000);

    wait (pend_q.size() == 0 && !item_ch.valid && want_q.size() == 0);
    repeat (200) @(posedge clk);

    $display("Covered %0d items and %0d result words across several register settings;",
             n_items, n_results);
    $display("largest eviction %0d, faded draws %0d, expired entries %0d.",
             n_evict_max, n_faded, n_freed);
    if (errors == 0 && want_q.size() == 0) begin
      $display("aging_entry_pool_with_fade_tb: done, clean");
    end else begin
      $display("aging_entry_pool_with_fade_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("%0t ns: timeout, %0d result words still expected", $time, want_q.size());
    $display("aging_entry_pool_with_fade_tb: done, errors");
    $finish;
  end

endmodule
